FILE: src/xcfp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the xor checked frame parser
// no dependencies

package xcfp_pkg;

  localparam int unsigned COUNT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
  localparam logic [9:0]         MIN_FRAME = 10'd5;

  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_COMMAND = 3'd1;
  localparam logic [2:0] ROLE_LENGTH  = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
  localparam logic [2:0] ROLE_TRAILER = 3'd4;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT     = 3'd1;
  localparam logic [2:0] STATUS_DELIMITER = 3'd2;
  localparam logic [2:0] STATUS_LENGTH    = 3'd3;
  localparam logic [2:0] STATUS_CHECKSUM  = 3'd4;

  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_TAIL   = 1'b1;

  localparam logic [7:0] HEADER_RESET = 8'hAA;
  localparam logic [7:0] TAIL_RESET   = 8'h55;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] tail_byte;
  } cfg_t;

  typedef struct packed {
    logic [2:0] byte_role;
    logic [7:0] byte_value;
    logic [7:0] payload_index;
    logic       frame_done;
    logic [2:0] frame_status;
    logic [7:0] command;
    logic [7:0] payload_length;
  } result_t;

endpackage

FILE: src/xcfp_cfg.sv
`timescale 1ns / 1ps
// apb register file holding the header and tail delimiters
// depends on xcfp_pkg

module xcfp_cfg import xcfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte <= HEADER_RESET;
      cfg.tail_byte   <= TAIL_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_HEADER: cfg.header_byte <= pwdata[7:0];
        REG_TAIL:   cfg.tail_byte   <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HEADER: prdata = {24'd0, cfg.header_byte};
      REG_TAIL:   prdata = {24'd0, cfg.tail_byte};
      default:    prdata = 32'd0;
    endcase
  end

  // unused low address bits
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

FILE: src/xcfp_track.sv
`timescale 1ns / 1ps
// frame position tracking, field capture, running xor and verdict
// depends on xcfp_pkg

module xcfp_track import xcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       frame_last,
  input  cfg_t       cfg,
  output result_t    result
);

  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         saved_command;
  logic [7:0]         saved_length;
  logic [7:0]         running_xor;
  logic               header_matched;
  logic               checksum_matched;

  logic [COUNT_W-1:0] byte_count_next;
  logic [7:0]         saved_command_next;
  logic [7:0]         saved_length_next;
  logic [7:0]         running_xor_next;
  logic               header_matched_next;
  logic               checksum_matched_next;

  logic [COUNT_W-1:0] pos_body;
  logic [COUNT_W-1:0] check_pos;
  logic [9:0]         flen;
  logic [9:0]         expect_len;
  logic               at_start;
  logic [2:0]         role;
  logic [7:0]         pidx;
  logic [2:0]         status;

  assign at_start   = (byte_count == '0);
  assign pos_body   = byte_count - 9'd3;
  assign check_pos  = {1'b0, saved_length_next} + 9'd3;
  assign flen       = {1'b0, byte_count} + 10'd1;
  assign expect_len = {2'b00, saved_length_next} + MIN_FRAME;

  always_comb begin
    saved_command_next = saved_command;
    saved_length_next  = saved_length;
    header_matched_next = header_matched;
    pidx = 8'd0;
    role = ROLE_TRAILER;
    if (at_start) begin
      saved_command_next  = 8'd0;
      saved_length_next   = 8'd0;
      header_matched_next = (in_byte == cfg.header_byte);
      role = ROLE_HEADER;
    end else if (byte_count == 9'd1) begin
      saved_command_next = in_byte;
      role = ROLE_COMMAND;
    end else if (byte_count == 9'd2) begin
      saved_length_next = in_byte;
      role = ROLE_LENGTH;
    end else if (pos_body < {1'b0, saved_length}) begin
      role = ROLE_PAYLOAD;
      pidx = pos_body[7:0];
    end

    checksum_matched_next = checksum_matched;
    if (byte_count >= 9'd3 && byte_count == check_pos) begin
      checksum_matched_next = (running_xor == in_byte);
    end
    running_xor_next = at_start ? running_xor : (running_xor ^ in_byte);
    byte_count_next  = (byte_count < COUNT_MAX) ? byte_count + 9'd1 : byte_count;

    status = STATUS_OK;
    if (frame_last) begin
      if (flen < MIN_FRAME) begin
        status = STATUS_SHORT;
      end else if (!header_matched_next || in_byte != cfg.tail_byte) begin
        status = STATUS_DELIMITER;
      end else if (byte_count >= COUNT_MAX || flen != expect_len) begin
        status = STATUS_LENGTH;
      end else if (!checksum_matched_next) begin
        status = STATUS_CHECKSUM;
      end
    end
  end

  always_comb begin
    result.byte_role      = role;
    result.byte_value     = in_byte;
    result.payload_index  = pidx;
    result.frame_done     = frame_last;
    result.frame_status   = status;
    result.command        = saved_command_next;
    result.payload_length = saved_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      saved_command    <= 8'd0;
      saved_length     <= 8'd0;
      running_xor      <= 8'd0;
      header_matched   <= 1'b0;
      checksum_matched <= 1'b0;
    end else if (accept) begin
      saved_command <= saved_command_next;
      saved_length  <= saved_length_next;
      if (frame_last) begin
        byte_count       <= '0;
        running_xor      <= 8'd0;
        header_matched   <= 1'b0;
        checksum_matched <= 1'b0;
      end else begin
        byte_count       <= byte_count_next;
        running_xor      <= running_xor_next;
        header_matched   <= header_matched_next;
        checksum_matched <= checksum_matched_next;
      end
    end
  end

endmodule

FILE: src/xcfp_obuf.sv
`timescale 1ns / 1ps
// two-entry result buffer between the tracker and the output channel
// depends on xcfp_pkg

module xcfp_obuf import xcfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  logic [1:0] count;
  result_t    entry1;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (count == 2'd2) begin
          head   <= entry1;
          entry1 <= push_data;
        end else begin
          head <= push_data;
        end
      end
      2'b10: begin
        if (count == 2'd0) begin
          head <= push_data;
        end else begin
          entry1 <= push_data;
        end
      end
      2'b01: head <= entry1;
      default: ;
    endcase
  end

endmodule

FILE: src/xor_checked_frame_parser.sv
`timescale 1ns / 1ps
// a byte's result enters the two-entry buffer when accepted and is offered once earlier results have left
// throughput: one byte per cycle while the input is not stalled, set by the single-pass tracker and two-entry buffer
// input stalls while both result buffer entries are held, which only a stalled output brings about
// reset: synchronous, returns to frame start, delimiters to 0xaa and 0x55
// depends on xcfp_pkg, xcfp_cfg, xcfp_track, xcfp_obuf

module xor_checked_frame_parser import xcfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  byte_role,
  output logic [7:0]  byte_value,
  output logic [7:0]  payload_index,
  output logic        frame_done,
  output logic [2:0]  frame_status,
  output logic [7:0]  command,
  output logic [7:0]  payload_length
);

  cfg_t    cfg;
  result_t result;
  result_t head;
  logic    accept;
  logic    full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  xcfp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  xcfp_track u_track (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_byte),
    .frame_last (frame_last),
    .cfg        (cfg),
    .result     (result)
  );

  xcfp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign byte_role      = head.byte_role;
  assign byte_value     = head.byte_value;
  assign payload_index  = head.payload_index;
  assign frame_done     = head.frame_done;
  assign frame_status   = head.frame_status;
  assign command        = head.command;
  assign payload_length = head.payload_length;

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("buffer full without a result at the head");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_done) |-> (frame_status == STATUS_OK))
    else $error("verdict on a byte that does not close the frame");

  a_index_only_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_role != ROLE_PAYLOAD) |-> (payload_index == 8'd0))
    else $error("payload index on a non-payload byte");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted byte produced no result");

endmodule

FILE: sim/xor_checked_frame_parser_test.sv
`timescale 1ns / 1ps
// self-checking testbench for xor_checked_frame_parser: directed and random frames,
// apb delimiter writes, random stalls on both sides, in-line byte parser prediction
// depends on xcfp_pkg and the xor_checked_frame_parser rtl

module xor_checked_frame_parser_test;
  import xcfp_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  typedef enum {FR_GOOD, FR_BAD_HEADER, FR_BAD_TAIL, FR_BAD_LENGTH, FR_BAD_SUM} frame_kind_t;

  localparam logic [2:0] ADDR_HEADER = {REG_HEADER, 2'b00};
  localparam logic [2:0] ADDR_TAIL   = {REG_TAIL, 2'b00};
  localparam int HOLD_CYCLES = 160;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        frame_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  byte_role;
  logic [7:0]  byte_value;
  logic [7:0]  payload_index;
  logic        frame_done;
  logic [2:0]  frame_status;
  logic [7:0]  command;
  logic [7:0]  payload_length;

  // parser state as the block should hold it
  logic [7:0] hdr_reg = HEADER_RESET;
  logic [7:0] tail_reg = TAIL_RESET;
  logic [8:0] pos_count = '0;
  logic [7:0] cap_cmd = '0;
  logic [7:0] cap_len = '0;
  logic [7:0] xor_acc = '0;
  logic       hdr_seen_ok = 1'b0;
  logic       sum_seen_ok = 1'b0;

  // delimiters that queued frames are built with
  logic [7:0] cur_hdr = HEADER_RESET;
  logic [7:0] cur_tail = TAIL_RESET;

  frame_byte_t frame_bytes_q[$];
  result_t     predicted_results[$];

  int src_idle = 0;
  int snk_idle = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_in_stalls = 0;
  int verdicts[5] = '{default: 0};
  bit in_taken = 1'b0;
  int hold_left = 0;
  int holds_done = 0;
  int next_hold = 300;

  xor_checked_frame_parser u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .frame_last     (frame_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .byte_role      (byte_role),
    .byte_value     (byte_value),
    .payload_index  (payload_index),
    .frame_done     (frame_done),
    .frame_status   (frame_status),
    .command        (command),
    .payload_length (payload_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic result_t parse_byte(logic [7:0] b, logic last);
    result_t r;
    int pos;
    int flen;
    pos = pos_count;
    r = '0;
    r.byte_value = b;
    r.frame_done = last;
    if (pos == 0) begin
      cap_cmd = '0;
      cap_len = '0;
      hdr_seen_ok = (b == hdr_reg);
      r.byte_role = ROLE_HEADER;
    end else if (pos == 1) begin
      cap_cmd = b;
      r.byte_role = ROLE_COMMAND;
    end else if (pos == 2) begin
      cap_len = b;
      r.byte_role = ROLE_LENGTH;
    end else if (pos - 3 < int'(cap_len)) begin
      r.byte_role = ROLE_PAYLOAD;
      r.payload_index = 8'(pos - 3);
    end else begin
      r.byte_role = ROLE_TRAILER;
    end
    if (pos >= 3 && pos == int'(cap_len) + 3) sum_seen_ok = (xor_acc == b);
    if (pos >= 1) xor_acc = xor_acc ^ b;
    if (pos_count < COUNT_MAX) pos_count = pos_count + 1'b1;
    r.command = cap_cmd;
    r.payload_length = cap_len;
    if (last) begin
      flen = pos + 1;
      if (flen < int'(MIN_FRAME)) r.frame_status = STATUS_SHORT;
      else if (!hdr_seen_ok || b != tail_reg) r.frame_status = STATUS_DELIMITER;
      else if (pos >= int'(COUNT_MAX) || flen != int'(cap_len) + int'(MIN_FRAME))
        r.frame_status = STATUS_LENGTH;
      else if (!sum_seen_ok) r.frame_status = STATUS_CHECKSUM;
      else r.frame_status = STATUS_OK;
      verdicts[r.frame_status]++;
      pos_count = '0;
      xor_acc = '0;
      hdr_seen_ok = 1'b0;
      sum_seen_ok = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // input side: prediction on acceptance, output side: comparison, apb: register shadow
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_HEADER: hdr_reg = pwdata[7:0];
          ADDR_TAIL:   tail_reg = pwdata[7:0];
          default: ;
        endcase
      end
      in_taken = in_valid && !in_stall;
      if (in_valid && in_stall) n_in_stalls++;
      if (in_taken) begin
        predicted_results.push_back(parse_byte(in_byte, frame_last));
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        got = {byte_role, byte_value, payload_index, frame_done, frame_status, command,
               payload_length};
        if (predicted_results.size() == 0) begin
          $error("result with no transaction pending: byte_value %0d", byte_value);
          n_errors++;
        end else begin
          want = predicted_results.pop_front();
          check_field("byte_role", want.byte_role, got.byte_role);
          check_field("byte_value", want.byte_value, got.byte_value);
          check_field("payload_index", want.payload_index, got.payload_index);
          check_field("frame_done", want.frame_done, got.frame_done);
          check_field("frame_status", want.frame_status, got.frame_status);
          check_field("command", want.command, got.command);
          check_field("payload_length", want.payload_length, got.payload_length);
          n_checked++;
        end
      end
    end
  end

  always @(negedge clk) begin
    frame_byte_t fb;
    if (!rst && (!in_valid || in_taken)) begin
      if (frame_bytes_q.size() > 0 && $urandom_range(99) >= src_idle) begin
        fb = frame_bytes_q.pop_front();
        in_valid <= 1'b1;
        in_byte <= fb.value;
        frame_last <= fb.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && n_accepted >= next_hold) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      next_hold += 700;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < snk_idle);
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [7:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {24'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_delimiters(logic [7:0] h, logic [7:0] t);
    write_reg(ADDR_HEADER, h);
    write_reg(ADDR_TAIL, t);
    cur_hdr = h;
    cur_tail = t;
  endtask

  task automatic push_byte(logic [7:0] b, logic last);
    frame_bytes_q.push_back('{value: b, last: last});
    n_queued++;
  endtask

  task automatic add_frame(frame_kind_t kind, int len, int n_pay);
    logic [7:0] cmd;
    logic [7:0] b;
    logic [7:0] sum;
    cmd = 8'($urandom);
    sum = cmd ^ 8'(len);
    if (kind == FR_BAD_HEADER) push_byte(cur_hdr ^ 8'($urandom_range(1, 255)), 1'b0);
    else push_byte(cur_hdr, 1'b0);
    push_byte(cmd, 1'b0);
    push_byte(8'(len), 1'b0);
    repeat (n_pay) begin
      b = 8'($urandom);
      sum = sum ^ b;
      push_byte(b, 1'b0);
    end
    if (kind == FR_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    push_byte(sum, 1'b0);
    if (kind == FR_BAD_TAIL) push_byte(cur_tail ^ 8'($urandom_range(1, 255)), 1'b1);
    else push_byte(cur_tail, 1'b1);
  endtask

  task automatic gen_random(int target);
    int stop;
    int r;
    int len;
    int pay;
    stop = n_queued + target;
    while (n_queued < stop) begin
      r = $urandom_range(99);
      len = ($urandom_range(39) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
      if (r < 58) begin
        add_frame(FR_GOOD, len, len);
      end else if (r < 66) begin
        add_frame(FR_BAD_SUM, len, len);
      end else if (r < 72) begin
        add_frame(FR_BAD_HEADER, len, len);
      end else if (r < 78) begin
        add_frame(FR_BAD_TAIL, len, len);
      end else if (r < 86) begin
        pay = $urandom_range(1) ? len + $urandom_range(1, 3) : len - $urandom_range(1, 3);
        if (pay < 0) pay = len + 1;
        add_frame(FR_BAD_LENGTH, len, pay);
      end else begin
        // raw bytes with stray frame ends, mostly too short
        repeat ($urandom_range(1, 7)) push_byte(8'($urandom), $urandom_range(3) == 0);
        push_byte(8'($urandom), 1'b1);
      end
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (frame_bytes_q.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    src_idle = 14;
    snk_idle = 45;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty payload, good frame
    push_byte(cur_hdr, 0); push_byte(8'h00, 0); push_byte(8'h00, 0);
    push_byte(8'h00, 0); push_byte(cur_tail, 1);
    // one-byte and four-byte frames
    push_byte(8'hFF, 1);
    push_byte(cur_hdr, 0); push_byte(8'hFF, 0); push_byte(8'h00, 0); push_byte(cur_tail, 1);
    // wrong header
    push_byte(8'h00, 0); push_byte(8'hFF, 0); push_byte(8'h00, 0);
    push_byte(8'hFF, 0); push_byte(cur_tail, 1);
    // wrong checksum
    push_byte(cur_hdr, 0); push_byte(8'hFF, 0); push_byte(8'h01, 0);
    push_byte(8'h80, 0); push_byte(8'h00, 0); push_byte(cur_tail, 1);
    // length byte promises more payload than the frame holds
    push_byte(cur_hdr, 0); push_byte(8'h00, 0); push_byte(8'h02, 0);
    push_byte(8'h7F, 0); push_byte(cur_tail, 1);
    drain();

    set_delimiters(8'h00, 8'hFF);
    gen_random(520);
    drain();

    src_idle = 45;
    snk_idle = 14;
    set_delimiters(8'hFF, 8'h00);
    add_frame(FR_GOOD, 255, 255);
    gen_random(260);
    drain();

    src_idle = 0;
    snk_idle = 0;
    set_delimiters(8'($urandom), 8'($urandom));
    // frame long enough to saturate the byte counter
    add_frame(FR_BAD_LENGTH, $urandom_range(255), 507 + $urandom_range(6));
    gen_random(120);
    drain();
    repeat (10) @(posedge clk);

    $display("%0d bytes checked over %0d frames: ok %0d, short %0d, delimiter %0d",
             n_checked, verdicts[0] + verdicts[1] + verdicts[2] + verdicts[3] + verdicts[4],
             verdicts[STATUS_OK], verdicts[STATUS_SHORT], verdicts[STATUS_DELIMITER]);
    $display("length %0d, checksum %0d; input held back for %0d cycles",
             verdicts[STATUS_LENGTH], verdicts[STATUS_CHECKSUM], n_in_stalls);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
